FILE: src/stoi_pkg.sv
package stoi_pkg;

  localparam int INDEX_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int RADIX_W    = 6;
  localparam int START_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int MAG_W      = 64;
  localparam int STOP_W     = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_RADIX = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_START = 1'd1;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
  localparam logic [RADIX_W-1:0] DIGIT_NONE  = 6'd36;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       char_valid;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              negative;
    logic [MAG_W-1:0]  magnitude;
    logic [STOP_W-1:0] stop_index;
  } out_t;

  // Character class worked out by the front end.
  typedef struct packed {
    logic [RADIX_W-1:0] digit;
    logic               space;
    logic               minus;
    logic               plus;
    logic               zero;
    logic               xchar;
    logic               early;
    logic               valid;
    logic               last;
  } class_t;

endpackage

FILE: src/string_to_integer_parser.sv
// Channel   Direction  Handshake                     Payload
// request   in         push / full                   char_byte, char_valid, last_char
// result    out        empty / pop                   status, negative, magnitude, stop_index
// cfg       in         cfg_write, cfg_index          cfg_data (radix, start_index)
//
// One character is taken per cycle unless the character queue is full; the parser handles
// one character each cycle as well unless none is queued or a last character meets a full
// result queue, bounded by the accumulate step (magnitude times base plus digit).
// The character queue lets requests keep arriving while results wait to be popped.
// Reset is synchronous and clears both queues, the position counter and the parse state.
module string_to_integer_parser #(
  parameter int INDEX_BITS  = stoi_pkg::INDEX_BITS_DEF,
  parameter int QUEUE_DEPTH = stoi_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  stoi_pkg::in_t                    request,
  output logic                             empty,
  input  logic                             pop,
  output stoi_pkg::out_t                   result,
  input  logic                             cfg_write,
  input  logic [stoi_pkg::CFG_ADDR_W-1:0]  cfg_index,
  input  logic [stoi_pkg::CFG_DATA_W-1:0]  cfg_data
);

  typedef struct packed {
    stoi_pkg::class_t      cls;
    logic [INDEX_BITS-1:0] pos;
  } item_t;

  logic [stoi_pkg::RADIX_W-1:0] radix;
  logic [stoi_pkg::START_W-1:0] start_index;

  logic                  accept;
  item_t                 front_item;
  item_t                 back_item;
  logic [$bits(item_t)-1:0] back_bits;
  logic                  item_empty;
  logic                  item_pop;
  logic                  result_full;
  logic                  result_push;
  stoi_pkg::out_t        back_result;
  logic [$bits(stoi_pkg::out_t)-1:0] result_bits;

  assign accept    = push && !full;
  assign back_item = item_t'(back_bits);
  assign result    = stoi_pkg::out_t'(result_bits);

  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= '0;
      start_index <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        stoi_pkg::REG_RADIX: radix       <= cfg_data[stoi_pkg::RADIX_W-1:0];
        stoi_pkg::REG_START: start_index <= cfg_data[stoi_pkg::START_W-1:0];
        default: begin
        end
      endcase
    end
  end

  stoi_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .request    (request),
    .start_index(start_index),
    .cls        (front_item.cls),
    .pos        (front_item.pos)
  );

  stoi_queue #(
    .WIDTH($bits(item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_item_queue (
    .clk  (clk),
    .rst  (rst),
    .push (accept),
    .wdata(front_item),
    .full (full),
    .pop  (item_pop),
    .rdata(back_bits),
    .empty(item_empty)
  );

  stoi_back #(
    .INDEX_BITS(INDEX_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_empty (item_empty),
    .cls        (back_item.cls),
    .pos        (back_item.pos),
    .item_pop   (item_pop),
    .radix      (radix),
    .result_full(result_full),
    .result_push(result_push),
    .result     (back_result)
  );

  stoi_queue #(
    .WIDTH($bits(stoi_pkg::out_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_result_queue (
    .clk  (clk),
    .rst  (rst),
    .push (result_push),
    .wdata(back_result),
    .full (result_full),
    .pop  (pop),
    .rdata(result_bits),
    .empty(empty)
  );

endmodule

FILE: src/stoi_queue.sv
module stoi_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = stoi_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/stoi_front.sv
module stoi_front #(
  parameter int INDEX_BITS = stoi_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  stoi_pkg::in_t                 request,
  input  logic [stoi_pkg::START_W-1:0]  start_index,
  output stoi_pkg::class_t              cls,
  output logic [INDEX_BITS-1:0]         pos
);

  localparam int CMP_W = (INDEX_BITS > stoi_pkg::START_W) ? INDEX_BITS : stoi_pkg::START_W;

  logic [INDEX_BITS-1:0] position;
  logic [7:0]            c;

  assign c   = request.char_byte;
  assign pos = position;

  always_comb begin
    cls        = '0;
    cls.space  = (c inside {stoi_pkg::CH_SPACE, [stoi_pkg::CH_TAB:stoi_pkg::CH_CR]});
    cls.minus  = (c == stoi_pkg::CH_MINUS);
    cls.plus   = (c == stoi_pkg::CH_PLUS);
    cls.zero   = (c == stoi_pkg::CH_0);
    cls.xchar  = (c == stoi_pkg::CH_LX) || (c == stoi_pkg::CH_UX);
    cls.early  = (CMP_W'(position) < CMP_W'(start_index));
    cls.valid  = request.char_valid;
    cls.last   = request.last_char;
    if (c inside {[stoi_pkg::CH_0:stoi_pkg::CH_9]}) begin
      cls.digit = 6'(c - stoi_pkg::CH_0);
    end else if (c inside {[stoi_pkg::CH_UA:stoi_pkg::CH_UZ]}) begin
      cls.digit = 6'(c - stoi_pkg::CH_UA) + stoi_pkg::RADIX_DEC;
    end else if (c inside {[stoi_pkg::CH_LA:stoi_pkg::CH_LZ]}) begin
      cls.digit = 6'(c - stoi_pkg::CH_LA) + stoi_pkg::RADIX_DEC;
    end else begin
      cls.digit = stoi_pkg::DIGIT_NONE;
    end
  end

  // The position counts characters of the current string and saturates.
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (accept) begin
      if (request.last_char) begin
        position <= '0;
      end else if (request.char_valid && (position != '1)) begin
        position <= position + 1'b1;
      end
    end
  end

endmodule

FILE: src/stoi_back.sv
module stoi_back #(
  parameter int INDEX_BITS = stoi_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_empty,
  input  stoi_pkg::class_t              cls,
  input  logic [INDEX_BITS-1:0]         pos,
  output logic                          item_pop,
  input  logic [stoi_pkg::RADIX_W-1:0]  radix,
  input  logic                          result_full,
  output logic                          result_push,
  output stoi_pkg::out_t                result
);

  localparam logic [2:0] PH_BEFORE = 3'd0;
  localparam logic [2:0] PH_SPACE  = 3'd1;
  localparam logic [2:0] PH_BASE   = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  localparam int MW = stoi_pkg::MAG_W;
  localparam int RW = stoi_pkg::RADIX_W;

  function automatic logic radix_bad(input logic [RW-1:0] r);
    radix_bad = (r != stoi_pkg::RADIX_AUTO) &&
                ((r < stoi_pkg::RADIX_MIN) || (r > stoi_pkg::RADIX_MAX));
  endfunction

  logic [2:0]            phase;
  logic [MW-1:0]         acc;
  logic                  minus_seen;
  logic [RW-1:0]         active_radix;
  logic [INDEX_BITS-1:0] stop_pos;
  logic [1:0]            error_code;
  logic                  any_digit;

  logic [2:0]            phase_next;
  logic [MW-1:0]         acc_next;
  logic                  minus_next;
  logic [RW-1:0]         radix_next;
  logic [INDEX_BITS-1:0] stop_next;
  logic [1:0]            error_next;
  logic                  any_next;

  logic                  take;
  logic                  adv;
  logic [RW-1:0]         base;
  logic [MW+RW-1:0]      prod;
  logic [MW+RW-1:0]      sum;
  logic                  ovf;
  logic [INDEX_BITS-1:0] end_pos;

  assign take        = !item_empty && (!cls.last || !result_full);
  assign item_pop    = take;
  assign result_push = take && cls.last;
  assign end_pos     = (cls.valid && (pos != '1)) ? pos + 1'b1 : pos;

  // Overflow is whatever spills above the top of the magnitude.
  assign prod = {{RW{1'b0}}, acc} * {{MW{1'b0}}, base};
  assign sum  = prod + (MW + RW)'(cls.digit);
  assign ovf  = |sum[MW+RW-1:MW];

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    minus_next = minus_seen;
    radix_next = active_radix;
    stop_next  = stop_pos;
    error_next = error_code;
    any_next   = any_digit;
    adv        = !cls.valid;
    base       = stoi_pkg::RADIX_DEC;

    if (!adv && (phase_next == PH_BEFORE)) begin
      if (cls.early) begin
        adv = 1'b1;
      end else begin
        phase_next = PH_SPACE;
      end
    end
    if (!adv && (phase_next == PH_SPACE)) begin
      if (cls.space) begin
        adv = 1'b1;
      end else begin
        phase_next = PH_BASE;
        if (cls.minus) begin
          minus_next = 1'b1;
          adv        = 1'b1;
        end else if (cls.plus) begin
          adv = 1'b1;
        end
      end
    end
    if (!adv && (phase_next == PH_BASE)) begin
      if ((radix == stoi_pkg::RADIX_AUTO) || (radix == stoi_pkg::RADIX_HEX)) begin
        if (cls.zero) begin
          radix_next = (radix == stoi_pkg::RADIX_AUTO) ? stoi_pkg::RADIX_OCT
                                                       : stoi_pkg::RADIX_HEX;
          phase_next = PH_ZERO;
          adv        = 1'b1;
        end else begin
          radix_next = (radix == stoi_pkg::RADIX_AUTO) ? stoi_pkg::RADIX_DEC
                                                       : stoi_pkg::RADIX_HEX;
          phase_next = PH_DIGITS;
        end
      end else if (radix_bad(radix)) begin
        phase_next = PH_DONE;
        error_next = stoi_pkg::ST_INVALID;
        stop_next  = '0;
        acc_next   = '0;
        adv        = 1'b1;
      end else begin
        radix_next = radix;
        phase_next = PH_DIGITS;
      end
    end else if (!adv && (phase_next == PH_ZERO)) begin
      phase_next = PH_DIGITS;
      if (cls.xchar) begin
        radix_next = stoi_pkg::RADIX_HEX;
        adv        = 1'b1;
      end else begin
        acc_next = '0;
        any_next = 1'b1;
      end
    end

    if ((radix_next >= stoi_pkg::RADIX_MIN) && (radix_next <= stoi_pkg::RADIX_MAX)) begin
      base = radix_next;
    end

    if (!adv && (phase_next == PH_DIGITS)) begin
      if (cls.digit >= base) begin
        phase_next = PH_DONE;
        stop_next  = pos;
        error_next = any_next ? stoi_pkg::ST_OK : stoi_pkg::ST_INVALID;
      end else if (ovf) begin
        phase_next = PH_DONE;
        stop_next  = pos;
        error_next = stoi_pkg::ST_OVERFLOW;
      end else begin
        acc_next = sum[MW-1:0];
        any_next = 1'b1;
      end
    end
  end

  always_comb begin
    result            = '0;
    result.status     = stoi_pkg::ST_INVALID;
    result.negative   = minus_next;
    case (phase_next)
      PH_SPACE, PH_BASE: begin
        result.stop_index = radix_bad(radix) ? '0 : stoi_pkg::STOP_W'(end_pos);
      end
      PH_ZERO: begin
        result.status     = stoi_pkg::ST_OK;
        result.stop_index = stoi_pkg::STOP_W'(end_pos);
      end
      PH_DIGITS: begin
        result.status     = any_next ? stoi_pkg::ST_OK : stoi_pkg::ST_INVALID;
        result.magnitude  = acc_next;
        result.stop_index = stoi_pkg::STOP_W'(end_pos);
      end
      PH_DONE: begin
        result.status     = error_next;
        result.magnitude  = acc_next;
        result.stop_index = stoi_pkg::STOP_W'(stop_next);
      end
      default: begin
        result.negative = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_BEFORE;
      acc          <= '0;
      minus_seen   <= 1'b0;
      active_radix <= '0;
      stop_pos     <= '0;
      error_code   <= '0;
      any_digit    <= 1'b0;
    end else if (take) begin
      if (cls.last) begin
        phase        <= PH_BEFORE;
        acc          <= '0;
        minus_seen   <= 1'b0;
        active_radix <= '0;
        stop_pos     <= '0;
        error_code   <= '0;
        any_digit    <= 1'b0;
      end else begin
        phase        <= phase_next;
        acc          <= acc_next;
        minus_seen   <= minus_next;
        active_radix <= radix_next;
        stop_pos     <= stop_next;
        error_code   <= error_next;
        any_digit    <= any_next;
      end
    end
  end

endmodule

FILE: verif/string_to_integer_parser_tb.sv
`timescale 1ns / 100ps

import stoi_pkg::*;

typedef enum logic [2:0] {
  SKIP_LEAD, SKIP_SPACE, READ_BASE, AFTER_ZERO, READ_DIGITS, PARSE_DONE
} parse_phase_e;

class parse_scoreboard;
  logic [RADIX_W-1:0] radix;
  logic [START_W-1:0] first_pos;
  parse_phase_e       phase;
  logic [15:0]        char_pos;
  logic [15:0]        stop_pos;
  logic [MAG_W-1:0]   acc;
  logic               minus;
  logic               any_digit;
  logic [1:0]         err;
  int unsigned        base;
  out_t               expected_q[$];
  int                 mismatches;
  int                 checked;

  function new();
    radix = RADIX_AUTO;
    first_pos = '0;
    mismatches = 0;
    checked = 0;
    restart();
  endfunction

  function void restart();
    phase = SKIP_LEAD;
    char_pos = '0;
    stop_pos = '0;
    acc = '0;
    minus = 1'b0;
    any_digit = 1'b0;
    err = ST_OK;
    base = 0;
  endfunction

  task report(string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_RADIX) radix = data[RADIX_W-1:0];
    else if (idx == REG_START) first_pos = data[START_W-1:0];
  endfunction

  function bit radix_bad();
    return radix != RADIX_AUTO && (radix < RADIX_MIN || radix > RADIX_MAX);
  endfunction

  function bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function int unsigned digit_val(logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return c - CH_0;
    if (c >= CH_UA && c <= CH_UZ) return c - CH_UA + 10;
    if (c >= CH_LA && c <= CH_LZ) return c - CH_LA + 10;
    return DIGIT_NONE;
  endfunction

  function void take_char(logic [7:0] c);
    logic [15:0]      pos;
    logic [MAG_W-1:0] maxv;
    logic [MAG_W-1:0] maxd;
    int unsigned      b;
    int unsigned      d;
    bit               skip;
    pos = char_pos;
    skip = 1'b0;
    if (phase == SKIP_LEAD) begin
      if (pos < first_pos) skip = 1'b1;
      else phase = SKIP_SPACE;
    end
    if (!skip && phase == SKIP_SPACE) begin
      if (is_space(c)) begin
        skip = 1'b1;
      end else begin
        phase = READ_BASE;
        if (c == CH_MINUS) begin
          minus = 1'b1;
          skip = 1'b1;
        end else if (c == CH_PLUS) begin
          skip = 1'b1;
        end
      end
    end
    if (!skip && phase == READ_BASE) begin
      if (radix == RADIX_AUTO || radix == RADIX_HEX) begin
        if (c == CH_0) begin
          base = (radix == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
          phase = AFTER_ZERO;
          skip = 1'b1;
        end else begin
          base = (radix == RADIX_AUTO) ? RADIX_DEC : RADIX_HEX;
          phase = READ_DIGITS;
        end
      end else if (radix_bad()) begin
        phase = PARSE_DONE;
        err = ST_INVALID;
        stop_pos = '0;
        acc = '0;
        skip = 1'b1;
      end else begin
        base = radix;
        phase = READ_DIGITS;
      end
    end else if (!skip && phase == AFTER_ZERO) begin
      phase = READ_DIGITS;
      if (c == CH_LX || c == CH_UX) begin
        base = RADIX_HEX;
        skip = 1'b1;
      end else begin
        // The leading zero counts as a digit of its own.
        acc = '0;
        any_digit = 1'b1;
      end
    end
    if (!skip && phase == READ_DIGITS) begin
      b = (base < RADIX_MIN || base > RADIX_MAX) ? RADIX_DEC : base;
      d = digit_val(c);
      if (d >= b) begin
        phase = PARSE_DONE;
        stop_pos = pos;
        err = any_digit ? ST_OK : ST_INVALID;
      end else begin
        maxv = {MAG_W{1'b1}} / MAG_W'(b);
        maxd = {MAG_W{1'b1}} % MAG_W'(b);
        if (acc > maxv || (acc == maxv && MAG_W'(d) > maxd)) begin
          phase = PARSE_DONE;
          stop_pos = pos;
          err = ST_OVERFLOW;
        end else begin
          acc = acc * MAG_W'(b) + MAG_W'(d);
          any_digit = 1'b1;
        end
      end
    end
    if (char_pos != 16'hFFFF) char_pos++;
  endfunction

  function out_t conclude();
    out_t r;
    r.status = ST_INVALID;
    r.negative = minus;
    r.magnitude = '0;
    r.stop_index = '0;
    case (phase)
      SKIP_SPACE, READ_BASE: r.stop_index = radix_bad() ? 16'd0 : char_pos;
      AFTER_ZERO: begin
        r.status = ST_OK;
        r.stop_index = char_pos;
      end
      READ_DIGITS: begin
        r.status = any_digit ? ST_OK : ST_INVALID;
        r.magnitude = acc;
        r.stop_index = char_pos;
      end
      PARSE_DONE: begin
        r.status = err;
        r.magnitude = acc;
        r.stop_index = stop_pos;
      end
      default: r.negative = 1'b0;
    endcase
    return r;
  endfunction

  function void note_request(in_t it);
    if (it.char_valid) take_char(it.char_byte);
    if (it.last_char) begin
      expected_q.push_back(conclude());
      restart();
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  task check_result(out_t got);
    out_t want;
    checked++;
    if (expected_q.size() == 0) begin
      report($sformatf("result %0d arrived with nothing expected", checked));
      return;
    end
    want = expected_q.pop_front();
    if (got.status !== want.status)
      report($sformatf("result %0d status %0d, expected %0d",
                       checked, got.status, want.status));
    if (got.negative !== want.negative)
      report($sformatf("result %0d negative %0b, expected %0b",
                       checked, got.negative, want.negative));
    if (got.magnitude !== want.magnitude)
      report($sformatf("result %0d magnitude %0h, expected %0h",
                       checked, got.magnitude, want.magnitude));
    if (got.stop_index !== want.stop_index)
      report($sformatf("result %0d stop_index %0d, expected %0d",
                       checked, got.stop_index, want.stop_index));
  endtask

  task check_drained();
    if (expected_q.size() != 0)
      report($sformatf("%0d results never arrived", expected_q.size()));
  endtask
endclass

module string_to_integer_parser_tb;
  logic                  clk;
  logic                  rst;
  logic                  push;
  logic                  full;
  in_t                   request;
  logic                  empty;
  logic                  pop;
  out_t                  result;
  logic                  cfg_write;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  parse_scoreboard    sb;
  in_t                str_items[$];
  int                 burst_left;
  int                 items_sent;
  bit                 scatter;
  logic [RADIX_W-1:0] cur_radix;
  logic [START_W-1:0] cur_start;

  string_to_integer_parser dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .request(request),
    .empty(empty),
    .pop(pop),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("string_to_integer_parser_tb NOT OK");
    $finish;
  end

  // Sends one request; bursts of back-to-back requests are separated by random gaps.
  task automatic send_item(input in_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    request <= it;
    do @(posedge clk); while (full);
    sb.note_request(it);
    items_sent++;
  endtask

  task automatic add_char(input logic [7:0] c, input logic valid);
    in_t it;
    if (scatter && $urandom_range(0, 19) == 0) begin
      it.char_byte = 8'($urandom);
      it.char_valid = 1'b0;
      it.last_char = 1'b0;
      str_items.push_back(it);
    end
    it.char_byte = c;
    it.char_valid = valid;
    it.last_char = 1'b0;
    str_items.push_back(it);
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) add_char(s[i], 1'b1);
  endtask

  // An empty string goes out as a single request without a character.
  task automatic send_string();
    in_t it;
    if (str_items.size() == 0) begin
      it.char_byte = 8'($urandom);
      it.char_valid = 1'b0;
      it.last_char = 1'b0;
      str_items.push_back(it);
    end
    it = str_items.pop_back();
    it.last_char = 1'b1;
    str_items.push_back(it);
    foreach (str_items[i]) send_item(str_items[i]);
    str_items.delete();
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    push <= 1'b0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(input logic [RADIX_W-1:0] rdx, input logic [START_W-1:0] first);
    logic [CFG_DATA_W-1:0] data;
    settle();
    data = CFG_DATA_W'($urandom);
    data[RADIX_W-1:0] = rdx;
    write_reg(REG_RADIX, data);
    write_reg(REG_START, first);
    cfg_write <= 1'b0;
    cur_radix = rdx;
    cur_start = first;
  endtask

  function automatic int digits_for(int b);
    logic [63:0] m;
    int n;
    m = '1;
    n = 0;
    while (m != 0) begin
      m = m / b;
      n++;
    end
    return n;
  endfunction

  function automatic logic [7:0] digit_char(int v);
    if (v < 10) return CH_0 + 8'(v);
    return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] x_char();
    return $urandom_range(0, 1) ? CH_LX : CH_UX;
  endfunction

  task automatic build_random_string();
    int kind;
    int base;
    int n;
    int lead;
    bit long_run;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(0, 8)) add_char(8'($urandom), $urandom_range(0, 4) != 0);
      return;
    end
    if (cur_start > 40) lead = $urandom_range(0, 6);
    else if (kind == 1) lead = $urandom_range(0, cur_start);
    else lead = cur_start;
    repeat (lead) add_char(8'($urandom), 1'b1);
    repeat ($urandom_range(0, 3))
      add_char(($urandom_range(0, 5) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)), 1'b1);
    case ($urandom_range(0, 2))
      1: add_char(CH_PLUS, 1'b1);
      2: add_char(CH_MINUS, 1'b1);
      default: ;
    endcase
    base = (cur_radix >= RADIX_MIN && cur_radix <= RADIX_MAX) ? cur_radix : RADIX_DEC;
    if (cur_radix == RADIX_AUTO) begin
      case ($urandom_range(0, 2))
        0: begin
          add_char(CH_0, 1'b1);
          add_char(x_char(), 1'b1);
          base = RADIX_HEX;
        end
        1: begin
          add_char(CH_0, 1'b1);
          base = RADIX_OCT;
        end
        default: ;
      endcase
    end else if (cur_radix == RADIX_HEX && $urandom_range(0, 1)) begin
      add_char(CH_0, 1'b1);
      add_char(x_char(), 1'b1);
    end
    long_run = 1'b0;
    case ($urandom_range(0, 9))
      0: n = 0;
      1, 2: begin
        // Around the largest digit count that fits in 64 bits, to reach overflow.
        n = digits_for(base) + $urandom_range(0, 2) - 1;
        long_run = 1'b1;
      end
      default: n = $urandom_range(1, 6);
    endcase
    repeat (n)
      add_char(digit_char((long_run && $urandom_range(0, 1)) ? base - 1
                                                              : $urandom_range(0, base - 1)),
               1'b1);
    if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) add_char(8'($urandom), 1'b1);
    if ($urandom_range(0, 9) == 0) add_char(8'($urandom), 1'b0);
  endtask

  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        pop <= 1'b0;
      end else begin
        if (pop && !empty) sb.check_result(result);
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: pop <= 1'b1;
          1: pop <= ($urandom_range(0, 3) != 0);
          default: pop <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin
    logic [RADIX_W-1:0] rdx;
    logic [START_W-1:0] first;
    sb = new();
    rst <= 1'b1;
    push <= 1'b0;
    request <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    burst_left = 0;
    items_sent = 0;
    scatter = 1'b0;
    cur_radix = RADIX_AUTO;
    cur_start = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    configure(RADIX_AUTO, 16'd0);
    send_string();
    add_char(CH_SPACE, 1'b1);
    for (int c = CH_TAB; c <= CH_CR; c++) add_char(8'(c), 1'b1);
    add_text("-123");
    send_string();
    add_text("+0x1F");
    send_string();
    add_text("0X");
    send_string();
    add_text("017");
    send_string();
    add_text("0");
    send_string();
    add_text("09");
    send_string();
    add_text("18446744073709551615");
    send_string();
    add_text("18446744073709551616");
    send_string();
    add_text("-");
    send_string();
    add_text("abc");
    send_string();
    add_text("12");
    add_char(8'hFF, 1'b0);
    add_text("3");
    add_char(8'h00, 1'b0);
    send_string();
    add_char(8'h80, 1'b1);
    send_string();

    configure(RADIX_HEX, 16'd0);
    add_text("0xfF");
    send_string();
    add_text("Ab");
    send_string();
    add_text("0");
    send_string();
    configure(RADIX_MAX, 16'd0);
    add_text("zZ9");
    send_string();
    add_text("zzzzzzzzzzzzzz");
    send_string();
    configure(RADIX_MIN, 16'd0);
    add_text("1012");
    send_string();
    configure(6'd1, 16'd0);
    add_text(" -5");
    send_string();
    configure(6'd37, 16'd0);
    add_text("+");
    send_string();
    configure(6'd63, 16'd0);
    add_text("7");
    send_string();
    configure(RADIX_DEC, 16'd3);
    add_text("xyz 42");
    send_string();
    add_text("ab");
    send_string();
    configure(RADIX_DEC, 16'hFFFF);
    add_text("9");
    send_string();

    scatter = 1'b1;
    while (items_sent < 1300) begin
      case ($urandom_range(0, 9))
        0, 1, 2: rdx = RADIX_AUTO;
        3: rdx = RADIX_HEX;
        4: rdx = RADIX_DEC;
        5, 6, 7: rdx = $urandom_range(RADIX_MIN, RADIX_MAX);
        8: rdx = $urandom_range(0, 1) ? RADIX_MIN : RADIX_MAX;
        default: rdx = $urandom_range(0, 1) ? 6'd1 : 6'($urandom_range(37, 63));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: first = '0;
        6, 7, 8: first = $urandom_range(1, 4);
        default: first = $urandom_range(0, 1) ? 16'($urandom_range(5, 40)) : 16'($urandom);
      endcase
      configure(rdx, first);
      repeat ($urandom_range(4, 12)) begin
        build_random_string();
        send_string();
      end
    end

    settle();
    sb.check_drained();
    if (sb.mismatches == 0) begin
      $display("string_to_integer_parser_tb OK");
    end else begin
      $display("string_to_integer_parser_tb NOT OK");
    end
    $finish;
  end
endmodule
